// ----- hw/rtl/pac_pkg.sv -----
package pac_pkg;

  // Width of one coordinate field on the input stream.
  localparam int unsigned COORD_IN_W = 16;
  localparam int unsigned IN_TDATA_W = 2 * COORD_IN_W;

  // Width of the reported doubled area; larger magnitudes saturate.
  localparam int unsigned AREA_W = 34;

  // Sign of the most recent nonzero corner turn.
  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_POS  = 2'd1,
    TURN_NEG  = 2'd2
  } turn_e;

  typedef struct packed {
    turn_e sign;
    logic  convex;
  } turn_st_t;

  // Fold one corner turn into the running convexity state; zero turns are skipped.
  function automatic turn_st_t note_turn(turn_st_t st, turn_e code);
    turn_st_t res;
    res = st;
    if (code != TURN_NONE) begin
      if (st.sign != TURN_NONE && st.sign != code) begin
        res.convex = 1'b0;
      end
      res.sign = code;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/polygon_area_convexity_unit.sv -----
// A final vertex passes the operand, product, difference, result and output registers before m_axis_tvalid.
// Throughput: one vertex per cycle; only a final vertex waiting on a full output
// register stalls the pipe (operand, multiply, difference, accumulate, output stages).
// Area magnitude and saturation are taken in the output stage.
// Reset clears vertex, count, sum and convexity state and empties every stage.
module polygon_area_convexity_unit
  import pac_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned COORD_BITS   = 16,
  localparam int unsigned CNT_W       = $clog2(MAX_VERTICES + 1),
  localparam int unsigned OUT_W       = AREA_W + 1 + CNT_W + 1,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // vx, vy
  input  logic                   s_axis_tlast,   // final_vertex
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // area_doubled, convex, vertex_total, overlong
);

  localparam int unsigned CW     = COORD_BITS;
  localparam int unsigned EW     = CW + 1;
  localparam int unsigned CP_W   = 2 * CW;
  localparam int unsigned TP_W   = 2 * CW + 2;
  localparam int unsigned TD_W   = 2 * CW + 3;
  localparam int unsigned DL_W   = 2 * CW + 2;
  localparam int unsigned SUM_W  = 2 * CW + 1 + CNT_W;
  localparam int unsigned CVX_BIT = AREA_W;
  localparam int unsigned TOT_LSB = AREA_W + 1;
  localparam int unsigned OVL_BIT = AREA_W + 1 + CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] CLOSE_MIN = CNT_W'(3);

  // ---------------------------------------------------------------------------
  // Handshake chain
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, m_valid_q;
  logic fin3_q;
  logic out_free, ld_out, s4_free, adv3, s3_free, adv2, s2_free, adv1, s1_free, s_acc;

  assign out_free = !m_valid_q || m_axis_tready;
  assign ld_out   = v4_q && out_free;
  assign s4_free  = !v4_q || ld_out;
  assign adv3     = v3_q && (!fin3_q || s4_free);
  assign s3_free  = !v3_q || adv3;
  assign adv2     = v2_q && s3_free;
  assign s2_free  = !v2_q || adv2;
  assign adv1     = v1_q && s2_free;
  assign s1_free  = !v1_q || adv1;
  assign s_acc    = s_axis_tvalid && s1_free;

  assign s_axis_tready = s1_free;
  assign m_axis_tvalid = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (s1_free) v1_q <= s_acc;
      if (s2_free) v2_q <= adv1;
      if (s3_free) v3_q <= adv2;
      if (s4_free) v4_q <= adv3 && fin3_q;
      if (out_free) m_valid_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: vertex ring state and operand selection
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] vx_c, vy_c;

  if (COORD_BITS <= COORD_IN_W) begin : g_coord_trunc
    assign vx_c = s_axis_tdata[CW-1:0];
    assign vy_c = s_axis_tdata[COORD_IN_W +: CW];
  end else begin : g_coord_ext
    assign vx_c = {{(CW - COORD_IN_W){1'b0}}, s_axis_tdata[COORD_IN_W-1:0]};
    assign vy_c = {{(CW - COORD_IN_W){1'b0}}, s_axis_tdata[COORD_IN_W +: COORD_IN_W]};
  end

  logic signed [CW-1:0] fx_q, fy_q, sx_q, sy_q, lx_q, ly_q, bx_q, by_q;
  logic [CNT_W-1:0]     count_q;
  logic                 over_q;

  logic                 counted, close_c, en_a, en_t0;
  logic [CNT_W-1:0]     cnt_new;
  logic                 over_new;
  logic signed [CW-1:0] lx_n, ly_n, bx_n, by_n, fx_n, fy_n, sx_n, sy_n;

  always_comb begin
    counted  = count_q < MAX_CNT;
    cnt_new  = counted ? count_q + CNT_W'(1) : count_q;
    over_new = over_q || !counted;
    lx_n     = counted ? vx_c : lx_q;
    ly_n     = counted ? vy_c : ly_q;
    bx_n     = counted ? lx_q : bx_q;
    by_n     = counted ? ly_q : by_q;
    fx_n     = (counted && count_q == '0) ? vx_c : fx_q;
    fy_n     = (counted && count_q == '0) ? vy_c : fy_q;
    sx_n     = (counted && count_q == CNT_W'(1)) ? vx_c : sx_q;
    sy_n     = (counted && count_q == CNT_W'(1)) ? vy_c : sy_q;
    en_a     = counted && count_q != '0;
    en_t0    = counted && count_q >= CNT_W'(2);
    close_c  = s_axis_tlast && cnt_new >= CLOSE_MIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q    <= '0;
      fy_q    <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      lx_q    <= '0;
      ly_q    <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      count_q <= '0;
      over_q  <= 1'b0;
    end else if (s_acc) begin
      if (s_axis_tlast) begin
        // start the next polygon from a clean ring
        fx_q    <= '0;
        fy_q    <= '0;
        sx_q    <= '0;
        sy_q    <= '0;
        lx_q    <= '0;
        ly_q    <= '0;
        bx_q    <= '0;
        by_q    <= '0;
        count_q <= '0;
        over_q  <= 1'b0;
      end else begin
        fx_q    <= fx_n;
        fy_q    <= fy_n;
        sx_q    <= sx_n;
        sy_q    <= sy_n;
        lx_q    <= lx_n;
        ly_q    <= ly_n;
        bx_q    <= bx_n;
        by_q    <= by_n;
        count_q <= cnt_new;
        over_q  <= over_new;
      end
    end
  end

  // Stage 1: cross operands and corner edges; disabled terms are zeroed so they
  // add nothing and count as no turn.
  logic signed [CW-1:0] ax1_q, ay1_q, bx1_q, by1_q;   // edge cross, previous vertex to new one
  logic signed [CW-1:0] cx1_q, cy1_q, dx1_q, dy1_q;   // closing edge cross
  logic signed [EW-1:0] e1x1_q [3];
  logic signed [EW-1:0] e1y1_q [3];
  logic signed [EW-1:0] e2x1_q [3];
  logic signed [EW-1:0] e2y1_q [3];
  logic                 fin1_q, close1_q, over1_q;
  logic [CNT_W-1:0]     cnt1_q;

  logic signed [CW-1:0] tpx [3];
  logic signed [CW-1:0] tpy [3];
  logic signed [CW-1:0] tqx [3];
  logic signed [CW-1:0] tqy [3];
  logic signed [CW-1:0] trx [3];
  logic signed [CW-1:0] tr_y [3];
  logic                 ten [3];

  always_comb begin
    ten[0] = en_t0;
    tpx[0] = bx_q;  tpy[0] = by_q;  tqx[0] = lx_q;  tqy[0] = ly_q;  trx[0] = vx_c; tr_y[0] = vy_c;
    ten[1] = close_c;
    tpx[1] = bx_n;  tpy[1] = by_n;  tqx[1] = lx_n;  tqy[1] = ly_n;  trx[1] = fx_q; tr_y[1] = fy_q;
    ten[2] = close_c;
    tpx[2] = lx_n;  tpy[2] = ly_n;  tqx[2] = fx_q;  tqy[2] = fy_q;  trx[2] = sx_q; tr_y[2] = sy_q;
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ax1_q    <= en_a ? lx_q : '0;
      ay1_q    <= en_a ? ly_q : '0;
      bx1_q    <= en_a ? vx_c : '0;
      by1_q    <= en_a ? vy_c : '0;
      cx1_q    <= close_c ? lx_n : '0;
      cy1_q    <= close_c ? ly_n : '0;
      dx1_q    <= close_c ? fx_q : '0;
      dy1_q    <= close_c ? fy_q : '0;
      for (int k = 0; k < 3; k++) begin
        e1x1_q[k] <= ten[k] ? EW'(tqx[k]) - EW'(tpx[k]) : '0;
        e1y1_q[k] <= ten[k] ? EW'(tqy[k]) - EW'(tpy[k]) : '0;
        e2x1_q[k] <= ten[k] ? EW'(trx[k]) - EW'(tqx[k]) : '0;
        e2y1_q[k] <= ten[k] ? EW'(tr_y[k]) - EW'(tqy[k]) : '0;
      end
      fin1_q   <= s_axis_tlast;
      close1_q <= close_c;
      over1_q  <= over_new;
      cnt1_q   <= cnt_new;
    end
  end

  // Stage 2: products
  logic signed [CP_W-1:0] pa1_q, pa2_q, pb1_q, pb2_q;
  logic signed [TP_W-1:0] tp1_q [3];
  logic signed [TP_W-1:0] tp2_q [3];
  logic                   fin2_q, close2_q, over2_q;
  logic [CNT_W-1:0]       cnt2_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      pa1_q <= ax1_q * by1_q;
      pa2_q <= bx1_q * ay1_q;
      pb1_q <= cx1_q * dy1_q;
      pb2_q <= dx1_q * cy1_q;
      for (int k = 0; k < 3; k++) begin
        tp1_q[k] <= e1x1_q[k] * e2y1_q[k];
        tp2_q[k] <= e2x1_q[k] * e1y1_q[k];
      end
      fin2_q   <= fin1_q;
      close2_q <= close1_q;
      over2_q  <= over1_q;
      cnt2_q   <= cnt1_q;
    end
  end

  // Stage 3: cross differences and turn signs
  logic signed [DL_W-1:0] delta_c;
  logic signed [TD_W-1:0] tdiff [3];
  turn_e                  tcode [3];

  always_comb begin
    delta_c = DL_W'(pa1_q) - DL_W'(pa2_q) + DL_W'(pb1_q) - DL_W'(pb2_q);
    for (int k = 0; k < 3; k++) begin
      tdiff[k] = TD_W'(tp1_q[k]) - TD_W'(tp2_q[k]);
      if (tdiff[k] == '0) begin
        tcode[k] = TURN_NONE;
      end else if (tdiff[k][TD_W-1]) begin
        tcode[k] = TURN_NEG;
      end else begin
        tcode[k] = TURN_POS;
      end
    end
  end

  logic signed [DL_W-1:0] delta3_q;
  turn_e                  tc3_q [3];
  logic                   close3_q, over3_q;
  logic [CNT_W-1:0]       cnt3_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      delta3_q <= delta_c;
      for (int k = 0; k < 3; k++) begin
        tc3_q[k] <= tcode[k];
      end
      close3_q <= close2_q;
      over3_q  <= over2_q;
      cnt3_q   <= cnt2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin3_q <= 1'b0;
    end else if (adv2) begin
      fin3_q <= fin2_q;
    end
  end

  // Accumulate on the way out of stage 3
  logic signed [SUM_W-1:0] sum_q, sum_d;
  turn_e                   tsign_q;
  logic                    cvx_q;
  turn_st_t                st0, st1, st2, st3;

  always_comb begin
    sum_d      = sum_q + SUM_W'(delta3_q);
    st0.sign   = tsign_q;
    st0.convex = cvx_q;
    st1        = note_turn(st0, tc3_q[0]);
    st2        = note_turn(st1, tc3_q[1]);
    st3        = note_turn(st2, tc3_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      tsign_q <= TURN_NONE;
      cvx_q   <= 1'b1;
    end else if (adv3) begin
      if (fin3_q) begin
        sum_q   <= '0;
        tsign_q <= TURN_NONE;
        cvx_q   <= 1'b1;
      end else begin
        sum_q   <= sum_d;
        tsign_q <= st3.sign;
        cvx_q   <= st3.convex;
      end
    end
  end

  // Stage 4: closed polygon result
  logic signed [SUM_W-1:0] sum4_q;
  logic                    cvx4_q, close4_q, over4_q;
  logic [CNT_W-1:0]        cnt4_q;

  always_ff @(posedge clk_i) begin
    if (adv3 && fin3_q) begin
      sum4_q   <= sum_d;
      cvx4_q   <= st3.convex;
      close4_q <= close3_q;
      over4_q  <= over3_q;
      cnt4_q   <= cnt3_q;
    end
  end

  // Output stage: magnitude and saturation
  logic [SUM_W-1:0]  mag;
  logic [AREA_W-1:0] area_sat;

  assign mag = sum4_q[SUM_W-1] ? SUM_W'(-sum4_q) : SUM_W'(sum4_q);

  if (SUM_W > AREA_W) begin : g_sat
    assign area_sat = (|mag[SUM_W-1:AREA_W]) ? {AREA_W{1'b1}} : mag[AREA_W-1:0];
  end else begin : g_nosat
    assign area_sat = AREA_W'(mag);
  end

  logic [OUT_TDATA_W-1:0] m_tdata_q, m_tdata_d;

  always_comb begin
    m_tdata_d                          = '0;
    m_tdata_d[AREA_W-1:0]              = close4_q ? area_sat : '0;
    m_tdata_d[CVX_BIT]                 = close4_q ? cvx4_q : 1'b1;
    m_tdata_d[TOT_LSB +: CNT_W]        = cnt4_q;
    m_tdata_d[OVL_BIT]                 = over4_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      m_tdata_q <= m_tdata_d;
    end
  end

  assign m_axis_tdata = m_tdata_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_short_poly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[TOT_LSB +: CNT_W] < CLOSE_MIN)
      |-> (m_axis_tdata[AREA_W-1:0] == '0) && m_axis_tdata[CVX_BIT])
    else $error("short polygon reported nonzero area or nonconvex");

  a_over_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OVL_BIT] |-> m_axis_tdata[TOT_LSB +: CNT_W] == MAX_CNT)
    else $error("overlong polygon without saturated vertex total");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tlast |=> (count_q == '0) && !over_q)
    else $error("ring state not cleared after final vertex");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("vertex count beyond maximum");

  a_cvx_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(cvx_q) |-> $past(tsign_q) != TURN_NONE)
    else $error("convexity lost without an earlier turn");

endmodule
